[design/csa_pkg.sv]
// Shared types, constants and helpers of the cosine similarity arbiter.
`default_nettype none
package csa_pkg;

  localparam int ELEM_WIDTH      = 16;
  localparam int DEFAULT_MAX_LEN = 64;
  localparam int DOT_W           = 38;
  localparam int NORM_W          = 37;
  localparam int PROD_W          = 2 * NORM_W;
  localparam int ROOT_W          = NORM_W;
  localparam int DEN_W           = 38;
  localparam int NUM_W           = DOT_W + 16;
  localparam int Q_W             = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_OFFSET = 3'd5;

  typedef enum logic [1:0] {
    MODE_THRESH  = 2'd0,
    MODE_HYST    = 2'd1,
    MODE_FILTER  = 2'd2,
    MODE_NEAREST = 2'd3
  } mode_t;

  localparam logic [14:0]        RST_THRESHOLD   = 15'd16384;
  localparam logic signed [15:0] RST_SWITCH_ON   = 16'sd19661;
  localparam logic signed [15:0] RST_SWITCH_OFF  = 16'sd13107;
  localparam logic [15:0]        RST_FILTER_GAIN = 16'd32768;
  localparam logic [15:0]        RST_NORM_OFFSET = 16'd1;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic signed [ELEM_WIDTH-1:0] elem_c;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] cos_ab;
    logic signed [Q_W-1:0] cos_ac;
    logic                  decision;
  } out_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot_ab;
    logic signed [DOT_W-1:0] dot_ac;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
    logic [NORM_W-1:0]       norm_c;
  } sums_t;

  typedef struct packed {
    mode_t                 mode;
    logic [14:0]           similarity_threshold;
    logic signed [15:0]    switch_on_level;
    logic signed [15:0]    switch_off_level;
    logic [15:0]           filter_gain;
    logic [15:0]           norm_offset;
  } cfg_t;

  // saturating signed accumulate
  function automatic logic signed [DOT_W-1:0] sat_dot(
      input logic signed [DOT_W-1:0] acc,
      input logic signed [2*ELEM_WIDTH-1:0] p);
    logic signed [DOT_W:0] s;
    s = (DOT_W+1)'(acc) + (DOT_W+1)'(p);
    if (s[DOT_W] != s[DOT_W-1]) begin
      sat_dot = s[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      sat_dot = s[DOT_W-1:0];
    end
  endfunction

  // saturating unsigned accumulate
  function automatic logic [NORM_W-1:0] sat_norm(
      input logic [NORM_W-1:0] acc,
      input logic [2*ELEM_WIDTH-1:0] p);
    logic [NORM_W:0] s;
    s = {1'b0, acc} + (NORM_W+1)'(p);
    sat_norm = s[NORM_W] ? {NORM_W{1'b1}} : s[NORM_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/csa_front.sv]
// Element front end: multiply-accumulate of dot products and squared norms.
`default_nettype none
module csa_front #(
  parameter int MAX_LEN = csa_pkg::DEFAULT_MAX_LEN
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire csa_pkg::in_t  in_data,
  output logic               push_valid,
  input  wire logic          push_ready,
  output csa_pkg::sums_t     push_data
);
  import csa_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0]        elem_count;
  logic signed [DOT_W-1:0] dot_ab_acc, dot_ac_acc;
  logic [NORM_W-1:0]       norm_a_acc, norm_b_acc, norm_c_acc;

  logic                           take, room;
  logic signed [2*ELEM_WIDTH-1:0] p_ab, p_ac, p_aa, p_bb, p_cc;
  sums_t                          sums_next;

  assign take     = in_valid && in_ready;
  assign in_ready = push_ready;
  assign room     = elem_count < CNT_W'(MAX_LEN);

  assign p_ab = in_data.elem_a * in_data.elem_b;
  assign p_ac = in_data.elem_a * in_data.elem_c;
  assign p_aa = in_data.elem_a * in_data.elem_a;
  assign p_bb = in_data.elem_b * in_data.elem_b;
  assign p_cc = in_data.elem_c * in_data.elem_c;

  always_comb begin
    if (room) begin
      sums_next.dot_ab = sat_dot(dot_ab_acc, p_ab);
      sums_next.dot_ac = sat_dot(dot_ac_acc, p_ac);
      sums_next.norm_a = sat_norm(norm_a_acc, $unsigned(p_aa));
      sums_next.norm_b = sat_norm(norm_b_acc, $unsigned(p_bb));
      sums_next.norm_c = sat_norm(norm_c_acc, $unsigned(p_cc));
    end else begin
      sums_next.dot_ab = dot_ab_acc;
      sums_next.dot_ac = dot_ac_acc;
      sums_next.norm_a = norm_a_acc;
      sums_next.norm_b = norm_b_acc;
      sums_next.norm_c = norm_c_acc;
    end
  end

  assign push_valid = take && in_data.last;
  assign push_data  = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      dot_ab_acc <= '0;
      dot_ac_acc <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
      norm_c_acc <= '0;
    end else if (take) begin
      if (in_data.last) begin
        elem_count <= '0;
        dot_ab_acc <= '0;
        dot_ac_acc <= '0;
        norm_a_acc <= '0;
        norm_b_acc <= '0;
        norm_c_acc <= '0;
      end else begin
        if (room) elem_count <= elem_count + 1'b1;
        dot_ab_acc <= sums_next.dot_ab;
        dot_ac_acc <= sums_next.dot_ac;
        norm_a_acc <= sums_next.norm_a;
        norm_b_acc <= sums_next.norm_b;
        norm_c_acc <= sums_next.norm_c;
      end
    end
  end

endmodule
`default_nettype wire

[design/csa_queue.sv]
// Short queue of finished vector sums between front and back end.
`default_nettype none
module csa_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire csa_pkg::sums_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output csa_pkg::sums_t       pop_data
);
  import csa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sums_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign push_ready = fill != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

[design/csa_back.sv]
// Back end: norm root, cosine division, filter and decision per vector.
`default_nettype none
module csa_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire csa_pkg::cfg_t   cfg,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire csa_pkg::sums_t  pop_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output csa_pkg::out_t        out_data
);
  import csa_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SQRT, S_DEN, S_DIV, S_SAT, S_NEXT,
    S_FILT_MUL, S_FILT_SUM, S_DECIDE, S_EMIT
  } state_t;

  state_t              state;
  sums_t               sums;
  logic                sel;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   prod, mcand;
  logic [NORM_W-1:0]   mplier;
  logic [ROOT_W-1:0]   root;
  logic [ROOT_W:0]     srem;
  logic [DEN_W-1:0]    den, drem;
  logic [NUM_W-1:0]    num, quo;
  logic                neg;
  logic signed [Q_W-1:0] cab, cac, prev;
  logic signed [33:0]  fp1, fp2;
  logic                hyst, dec;

  logic [ROOT_W+2:0]   sq_rem, sq_trial;
  logic [DEN_W:0]      dv_rem;
  logic signed [DOT_W-1:0] dot_sel;
  logic [DOT_W-1:0]    mag;
  logic [DEN_W-1:0]    den_w;
  logic [16:0]         gain;
  logic signed [34:0]  fsum;
  logic signed [19:0]  fval;
  logic signed [Q_W-1:0] fsat, qsat;
  logic                emit_ok;

  always_comb begin
    sq_rem   = {srem, prod[PROD_W-1 -: 2]};
    sq_trial = {1'b0, root, 2'b01};
    dv_rem   = {drem, num[NUM_W-1]};
    dot_sel  = sel ? sums.dot_ac : sums.dot_ab;
    mag      = dot_sel[DOT_W-1] ? $unsigned(-dot_sel) : $unsigned(dot_sel);
    den_w    = DEN_W'(root) + DEN_W'(cfg.norm_offset);
    gain     = (cfg.filter_gain > 16'd32768) ? 17'd32768 : {1'b0, cfg.filter_gain};
    fsum     = 35'(fp1) + 35'(fp2) + 35'sd16384;
    fval     = fsum[34:15];
    if (fval > 20'sd32767)       fsat = 16'sh7FFF;
    else if (fval < -20'sd32768) fsat = 16'sh8000;
    else                         fsat = fval[15:0];
    if (neg) qsat = (quo > NUM_W'(32768)) ? 16'sh8000 : -$signed(quo[15:0]);
    else     qsat = (quo > NUM_W'(32767)) ? 16'sh7FFF : $signed(quo[15:0]);
    emit_ok  = !out_valid || out_ready;
  end

  assign pop_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hyst      <= 1'b1;
      prev      <= '0;
    end else begin
      // S_EMIT reloads the output register itself when it is freed
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            sums   <= pop_data;
            sel    <= 1'b0;
            cac    <= '0;
            prod   <= '0;
            mcand  <= PROD_W'(pop_data.norm_a);
            mplier <= pop_data.norm_b;
            step   <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (step == STEP_W'(NORM_W - 1)) begin
            step  <= '0;
            root  <= '0;
            srem  <= '0;
            state <= S_SQRT;
          end else begin
            step  <= step + 1'b1;
          end
        end
        S_SQRT: begin
          // one result bit per cycle, two radicand bits consumed
          if (sq_rem >= sq_trial) begin
            srem <= (ROOT_W+1)'(sq_rem - sq_trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= (ROOT_W+1)'(sq_rem);
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          prod <= prod << 2;
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) state <= S_DEN;
        end
        S_DEN: begin
          neg  <= dot_sel[DOT_W-1];
          den  <= den_w;
          num  <= (NUM_W'(mag) << 15) + NUM_W'(den_w >> 1);
          drem <= '0;
          quo  <= '0;
          step <= '0;
          if (den_w == '0) begin
            if (sel) cac <= '0;
            else     cab <= '0;
            state <= S_NEXT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_rem >= {1'b0, den}) begin
            drem <= DEN_W'(dv_rem - {1'b0, den});
            quo  <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            drem <= dv_rem[DEN_W-1:0];
            quo  <= {quo[NUM_W-2:0], 1'b0};
          end
          num  <= num << 1;
          step <= step + 1'b1;
          if (step == STEP_W'(NUM_W - 1)) state <= S_SAT;
        end
        S_SAT: begin
          if (sel) cac <= qsat;
          else     cab <= qsat;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (cfg.mode == MODE_NEAREST && !sel) begin
            sel    <= 1'b1;
            prod   <= '0;
            mcand  <= PROD_W'(sums.norm_a);
            mplier <= sums.norm_c;
            step   <= '0;
            state  <= S_MUL;
          end else if (cfg.mode == MODE_FILTER) begin
            state <= S_FILT_MUL;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_FILT_MUL: begin
          fp1   <= $signed({1'b0, gain}) * cab;
          fp2   <= $signed({1'b0, 17'd32768 - gain}) * prev;
          state <= S_FILT_SUM;
        end
        S_FILT_SUM: begin
          cab   <= fsat;
          prev  <= fsat;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          case (cfg.mode)
            MODE_HYST: begin
              if (cab > cfg.switch_on_level && hyst) begin
                hyst <= 1'b0;
                dec  <= 1'b0;
              end else if (cab < cfg.switch_off_level && !hyst) begin
                hyst <= 1'b1;
                dec  <= 1'b1;
              end else begin
                dec <= hyst;
              end
            end
            MODE_NEAREST: dec <= (cab >= cac) ? 1'b0 : 1'b1;
            default: dec <= ($signed({cab[Q_W-1], cab}) > $signed({2'b00, cfg.similarity_threshold}))
                            ? 1'b0 : 1'b1;
          endcase
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_data.cos_ab   <= cab;
            out_data.cos_ac   <= cac;
            out_data.decision <= dec;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/cosine_similarity_arbiter_unit.sv]
// Top level of the cosine similarity arbiter: config registers, front, queue, back.
`default_nettype none
// Streams elements of vectors a, b and c, one index per transfer, and for every
// transfer marked last returns one result: the Q1.15 cosine of a and b (filtered
// in filter mode), the cosine of a and c (nearest mode only, else 0) and a
// decision bit. The front end takes one element transfer per cycle with a
// multiply-accumulate; sums saturate and elements past MAX_LEN are dropped
// until last. Finished sums wait in a two-entry queue for the back end, which
// handles one vector at a time: per cosine a shift-add norm product, a digit
// square root and a restoring divide, twice in nearest mode, then filter and
// decision steps. The back end's iterative steps set the vector rate; the front
// stalls only when the queue is full. Config writes go straight to registers
// and belong only to an idle block; the user must keep to this, as the block
// itself does not enforce it.
module cosine_similarity_arbiter_unit #(
  parameter int MAX_LEN = csa_pkg::DEFAULT_MAX_LEN
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire csa_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output csa_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [csa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [csa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import csa_pkg::*;

  cfg_t  cfg;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  sums_t push_data, pop_data;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode                 <= MODE_THRESH;
      cfg.similarity_threshold <= RST_THRESHOLD;
      cfg.switch_on_level      <= RST_SWITCH_ON;
      cfg.switch_off_level     <= RST_SWITCH_OFF;
      cfg.filter_gain          <= RST_FILTER_GAIN;
      cfg.norm_offset          <= RST_NORM_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        cfg.mode                 <= mode_t'(cfg_wdata[1:0]);
        REG_THRESHOLD:   cfg.similarity_threshold <= cfg_wdata[14:0];
        REG_SWITCH_ON:   cfg.switch_on_level      <= $signed(cfg_wdata);
        REG_SWITCH_OFF:  cfg.switch_off_level     <= $signed(cfg_wdata);
        REG_FILTER_GAIN: cfg.filter_gain          <= cfg_wdata;
        REG_NORM_OFFSET: cfg.norm_offset          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: one element per cycle while the queue has room, pushes sums on last
  csa_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  // decouples the element stream from the per-vector math
  csa_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  // back: norm product, root, divide, filter, decision, output register
  csa_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the cosine similarity arbiter unit.
`timescale 1ns / 100ps
module testbench;
  import csa_pkg::*;

  localparam int VEC_MAX = 64;
  localparam int TOTAL_ITEMS = 1900;
  // slowest case: back-end work per vector plus stalls and gaps
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cosine_similarity_arbiter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of config and accumulators
  // ---------------------------------------------------------------------------
  logic [1:0]         p_mode;
  logic [14:0]        p_thresh;
  logic signed [15:0] p_on, p_off;
  logic [15:0]        p_gain, p_eps;
  logic signed [37:0] acc_ab, acc_ac;
  logic [36:0]        sq_a, sq_b, sq_c;
  logic               hyst_bit;
  logic signed [15:0] filt_prev;
  int                 elems_held;

  out_t cos_expected[$];
  in_t  pending_elems[$];

  int errors = 0;
  int results_seen = 0;
  int mode_hits[4] = '{0, 0, 0, 0};
  longint cycles = 0;

  function automatic logic signed [37:0] dot_sat(logic signed [37:0] acc,
                                                   logic signed [31:0] p);
    logic signed [63:0] s;
    s = 64'(acc) + 64'(p);
    if (s > 64'sd137438953471) return 38'sh1F_FFFF_FFFF;
    if (s < -64'sd137438953472) return {1'b1, 37'd0};
    return s[37:0];
  endfunction

  function automatic logic [36:0] sq_sat(logic [36:0] acc, logic [31:0] p);
    logic [37:0] s;
    s = {1'b0, acc} + 38'(p);
    return s[37] ? '1 : s[36:0];
  endfunction

  // floor(sqrt(x*y)) by bitwise search over a 74-bit product
  function automatic logic [37:0] norm_root(logic [36:0] x, logic [36:0] y);
    logic [75:0] prod, t2;
    logic [37:0] r, t;
    prod = 76'(x) * 76'(y);
    r = '0;
    for (int bit_i = 37; bit_i >= 0; bit_i--) begin
      t = r | (38'd1 << bit_i);
      t2 = 76'(t) * 76'(t);
      if (t2 <= prod) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] q15_cosine(logic signed [37:0] d,
                                                     logic [36:0] nx, logic [36:0] ny);
    logic [39:0] den;
    logic [37:0] mag;
    logic [55:0] q;
    den = 40'(norm_root(nx, ny)) + 40'(p_eps);
    if (den == 0) return 16'sd0;
    mag = d < 0 ? 38'(-d) : 38'(d);
    q = ((56'(mag) << 15) + 56'(den >> 1)) / 56'(den);
    if (d < 0) return q > 32768 ? -16'sd32768 : 16'(-$signed(57'(q)));
    return q > 32767 ? 16'sd32767 : 16'(q);
  endfunction

  task automatic predict_element(input in_t it);
    logic signed [15:0] cab, cac;
    logic signed [63:0] g, x, f;
    logic dec;
    out_t r;
    if (elems_held < VEC_MAX) begin
      acc_ab = dot_sat(acc_ab, it.elem_a * it.elem_b);
      acc_ac = dot_sat(acc_ac, it.elem_a * it.elem_c);
      sq_a = sq_sat(sq_a, 32'(it.elem_a * it.elem_a));
      sq_b = sq_sat(sq_b, 32'(it.elem_b * it.elem_b));
      sq_c = sq_sat(sq_c, 32'(it.elem_c * it.elem_c));
      elems_held++;
    end
    if (!it.last) return;
    cab = q15_cosine(acc_ab, sq_a, sq_b);
    cac = 16'sd0;
    case (mode_t'(p_mode))
      MODE_THRESH: dec = (32'(cab) > $signed({17'd0, p_thresh})) ? 1'b0 : 1'b1;
      MODE_HYST: begin
        if (cab > p_on && hyst_bit) hyst_bit = 1'b0;
        else if (cab < p_off && !hyst_bit) hyst_bit = 1'b1;
        dec = hyst_bit;
      end
      MODE_FILTER: begin
        g = p_gain > 16'd32768 ? 64'sd32768 : 64'(p_gain);
        x = g * 64'(cab) + (64'sd32768 - g) * 64'(filt_prev);
        f = (x + 64'sd16384) >>> 15;
        if (f > 32767) f = 32767;
        if (f < -32768) f = -32768;
        cab = 16'(f);
        filt_prev = cab;
        dec = (32'(cab) > $signed({17'd0, p_thresh})) ? 1'b0 : 1'b1;
      end
      default: begin
        cac = q15_cosine(acc_ac, sq_a, sq_c);
        dec = (cab >= cac) ? 1'b0 : 1'b1;
      end
    endcase
    r.cos_ab = cab;
    r.cos_ac = cac;
    r.decision = dec;
    cos_expected.push_back(r);
    mode_hits[p_mode]++;
    acc_ab = '0; acc_ac = '0; sq_a = '0; sq_b = '0; sq_c = '0;
    elems_held = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, inputs change on the falling edge
  // ---------------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;
  logic in_ready_seen = 1'b0;
  always @(negedge clk) begin
    // move on only when idle or the held transfer went through
    if (!rst && (!in_valid || in_ready_seen)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_elems.size() != 0) begin
        in_data <= pending_elems.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: periodic windows plus random stalls
  always @(negedge clk) begin
    if (!rst) out_ready <= ((cycles % 97) < 60) ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample at rising edge
  // ---------------------------------------------------------------------------
  int accepted = 0;
  always @(posedge clk) begin
    out_t e;
    cycles <= cycles + 1;
    in_ready_seen <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      predict_element(in_data);
      accepted <= accepted + 1;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (cos_expected.size() == 0) begin
        $error("unexpected transfer cos_ab=%0d", out_data.cos_ab);
        errors++;
      end else begin
        e = cos_expected.pop_front();
        if (out_data.cos_ab !== e.cos_ab) begin
          $error("cos_ab expected %0d actual %0d", e.cos_ab, out_data.cos_ab);
          errors++;
        end
        if (out_data.cos_ac !== e.cos_ac) begin
          $error("cos_ac expected %0d actual %0d", e.cos_ac, out_data.cos_ac);
          errors++;
        end
        if (out_data.decision !== e.decision) begin
          $error("decision expected %0d actual %0d", e.decision, out_data.decision);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int queued = 0;

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_elem(input logic signed [15:0] a, b, c, input logic lst);
    in_t it;
    it.elem_a = a; it.elem_b = b; it.elem_c = c; it.last = lst;
    pending_elems.push_back(it);
    queued++;
  endtask

  // random vector: short mostly, some long around MAX_LEN; b/c correlated with a in some kinds
  task automatic push_vector();
    int len, kind;
    logic signed [15:0] a;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 8);
    kind = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      a = rand_elem();
      case (kind)
        0: push_elem(a, a, -a, i == len - 1);
        1: push_elem(a, a + 16'($urandom_range(0, 255)), rand_elem(), i == len - 1);
        default: push_elem(a, rand_elem(), rand_elem(), i == len - 1);
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      REG_MODE:        p_mode = val[1:0];
      REG_THRESHOLD:   p_thresh = val[14:0];
      REG_SWITCH_ON:   p_on = val;
      REG_SWITCH_OFF:  p_off = val;
      REG_FILTER_GAIN: p_gain = val;
      REG_NORM_OFFSET: p_eps = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every transfer to drain, then let the back end settle
  task automatic drain();
    while (pending_elems.size() != 0 || in_valid || cos_expected.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_config();
    write_reg(REG_MODE, 16'($urandom_range(0, 3)));
    write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ? 16'h7FFF : 16'($urandom));
    write_reg(REG_SWITCH_ON, 16'($urandom_range(0, 40000) - 20000));
    write_reg(REG_SWITCH_OFF, 16'($urandom_range(0, 40000) - 20000));
    write_reg(REG_FILTER_GAIN, ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 32768)));
    write_reg(REG_NORM_OFFSET, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
  endtask

  initial begin
    p_mode = MODE_THRESH; p_thresh = RST_THRESHOLD; p_on = RST_SWITCH_ON;
    p_off = RST_SWITCH_OFF; p_gain = RST_FILTER_GAIN; p_eps = RST_NORM_OFFSET;
    acc_ab = '0; acc_ac = '0; sq_a = '0; sq_b = '0; sq_c = '0;
    hyst_bit = 1'b1; filt_prev = '0; elems_held = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero denominator, nearest tie, ignored index
    write_reg(REG_NORM_OFFSET, 16'd0);
    push_elem(16'sd0, 16'sd0, 16'sd0, 1'b1);
    push_elem(-16'sd32768, -16'sd32768, 16'sd32767, 1'b0);
    push_elem(16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    push_elem(-16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
    drain();
    write_reg(REG_MODE, 16'(MODE_NEAREST));
    write_reg(3'd7, 16'hFFFF);
    push_elem(16'sd5, 16'sd3, 16'sd3, 1'b1);
    push_elem(16'sd5, 16'sd3, -16'sd3, 1'b1);
    for (int i = 0; i < 70; i++) push_elem(-16'sd32768, -16'sd32768, 16'sd1, i == 69);
    drain();
    write_reg(REG_MODE, 16'(MODE_FILTER));
    write_reg(REG_FILTER_GAIN, 16'hFFFF);
    write_reg(REG_NORM_OFFSET, 16'hFFFF);
    push_elem(16'sd100, 16'sd100, 16'sd0, 1'b1);
    drain();
    write_reg(REG_FILTER_GAIN, 16'd0);
    write_reg(REG_THRESHOLD, 16'h0000);
    push_elem(16'sd100, -16'sd100, 16'sd0, 1'b1);
    drain();
    write_reg(REG_MODE, 16'(MODE_HYST));
    write_reg(REG_SWITCH_ON, 16'h8000);
    write_reg(REG_SWITCH_OFF, 16'h7FFF);
    push_elem(16'sd9, 16'sd9, 16'sd0, 1'b1);
    push_elem(16'sd9, -16'sd9, 16'sd0, 1'b1);
    drain();

    // random phases with new settings between them
    while (queued < TOTAL_ITEMS) begin
      random_config();
      for (int v = 0; v < 20 && queued < TOTAL_ITEMS; v++) push_vector();
      drain();
    end

    $display("%0d elements, %0d results; per mode thr/hyst/filt/near: %0d/%0d/%0d/%0d",
             accepted, results_seen, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("directed extremes, saturation and ties, then random phases in every mode");
    if (errors == 0 && cos_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[cosine_similarity_arbiter_unit.f]
design/csa_pkg.sv
design/csa_front.sv
design/csa_queue.sv
design/csa_back.sv
design/cosine_similarity_arbiter_unit.sv
bench/testbench.sv
